// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/etxrps_pkg.sv
// Package: types, widths and reset values for the ETX rank and parent selector
package etxrps_pkg;

    localparam int unsigned CostW  = 16;
    localparam int unsigned EtxW   = 16;
    localparam int unsigned MultW  = 10;
    localparam int unsigned IdW    = 8;
    localparam int unsigned ProdW  = EtxW + MultW;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned InDataW  = 104;
    localparam int unsigned OutDataW = 32;

    localparam int unsigned DefIdBits       = 8;
    localparam int unsigned DefEtxFracBits  = 8;

    localparam logic [CostW-1:0] RstMaxPathCost  = 16'd32768;
    localparam logic [CostW-1:0] RstMaxLinkMetric = 16'd512;
    localparam logic [MultW-1:0] RstEtxMultiplier = 10'd128;
    localparam logic [CostW-1:0] RstSwitchThresh = 16'd192;
    localparam logic [CostW-1:0] RstDefHopInc    = 16'd256;
    localparam logic [CostW-1:0] RstInfRank      = 16'd65535;
    localparam logic [CostW-1:0] RstMinHopInc    = 16'd256;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COST_CEILING    = 3'd0,
        REG_LINK_LIMIT      = 3'd1,
        REG_ETX_MULTIPLIER  = 3'd2,
        REG_SWITCH_THRESH   = 3'd3,
        REG_DEF_HOP_INC     = 3'd4,
        REG_INF_RANK        = 3'd5,
        REG_MIN_HOP_INC     = 3'd6
    } t_reg_idx;

    typedef enum logic {
        OP_RANK   = 1'b0,
        OP_CHOOSE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [CostW-1:0] cost_ceiling;
        logic [CostW-1:0] link_cost_limit;
        logic [MultW-1:0] etx_multiplier;
        logic [CostW-1:0] switch_threshold;
        logic [CostW-1:0] default_hop_increase;
        logic [CostW-1:0] infinite_rank_value;
        logic [CostW-1:0] min_hop_increase;
    } t_cfg;

    typedef struct packed {
        logic             opcode;
        logic             a_present;
        logic [IdW-1:0]   a_id;
        logic [EtxW-1:0]  a_etx;
        logic [CostW-1:0] a_rank;
        logic             b_present;
        logic [IdW-1:0]   b_id;
        logic [EtxW-1:0]  b_etx;
        logic [CostW-1:0] b_rank;
        logic [CostW-1:0] base_hint;
        logic             preferred_in_use;
    } t_item;

    typedef struct packed {
        logic             kept_previous;
        logic             chosen_present;
        logic [IdW-1:0]   chosen_id;
        logic [CostW-1:0] node_rank;
    } t_result;

endpackage

// File: src/etx_rank_and_parent_selector_top.sv
// ETX rank and parent selector: path cost, own rank and preferred parent choice
// One transaction is taken per clock cycle unless the input stalls; each accepted
// transaction is held in the input register and its result in the result register.
// The input side stalls only while both registers are full and the result is not taken.
// Opcode 0 derives the node rank from parent A; opcode 1 picks the cheaper of parents A
// and B (B on a tie), keeping the stored preferred parent under hysteresis. The preferred
// parent state is updated as each result is loaded. Configuration is written through a
// plain write port.
module etx_rank_and_parent_selector_top #(
    parameter int unsigned ID_BITS       = etxrps_pkg::DefIdBits,
    parameter int unsigned ETX_FRAC_BITS = etxrps_pkg::DefEtxFracBits
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // a_present, a_id, a_etx, a_rank, b_present, b_id, b_etx, b_rank,
    // base_hint, preferred_in_use, zero fill
    input  logic [etxrps_pkg::InDataW-1:0]    i_s_tdata,
    // opcode
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // node_rank, chosen_id, chosen_present, kept_previous, zero fill
    output logic [etxrps_pkg::OutDataW-1:0]   o_m_tdata,
    input  logic                              i_cfg_we,
    input  logic [etxrps_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [etxrps_pkg::CfgDataW-1:0]   i_cfg_wdata
);
    import etxrps_pkg::*;
`include "assert_macros.svh"

    localparam logic [IdW-1:0] IdMask = IdW'((32'd1 << ID_BITS) - 32'd1);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_item             r_in;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_pref_valid;
    logic [IdW-1:0]    r_pref_id;
    logic [CostW-1:0]  r_pref_cost;

    logic              s_accept;
    logic              advance;
    t_item             in_item;
    logic [CostW-1:0]  cost_a;
    logic [CostW-1:0]  cost_b;
    logic [CostW:0]    hop_sum;
    logic [CostW-1:0]  hop_rank;
    logic [CostW:0]    thr_a;
    logic [CostW:0]    thr_b;
    logic              keep;
    logic              win_b;
    logic              win_present;
    logic [IdW-1:0]    win_id;
    logic [CostW-1:0]  win_cost;
    t_result           n_out;
    logic              n_pref_valid;
    logic [IdW-1:0]    n_pref_id;
    logic [CostW-1:0]  n_pref_cost;

    function automatic logic [CostW-1:0] f_path_cost(
        input t_cfg             cfg,
        input logic             present,
        input logic [EtxW-1:0]  etx,
        input logic [CostW-1:0] rank
    );
        logic [ProdW-1:0] prod;
        logic [ProdW-1:0] link;
        logic [CostW:0]   sum;
        logic [CostW-1:0] cost;
        prod = ProdW'(etx) * ProdW'(cfg.etx_multiplier);
        link = prod >> ETX_FRAC_BITS;
        sum  = {1'b0, rank} + (CostW+1)'(link);
        if (!present) begin
            cost = cfg.default_hop_increase;
        end else if (etx == '0) begin
            cost = cfg.cost_ceiling;
        end else if (link > ProdW'(cfg.link_cost_limit)) begin
            cost = cfg.cost_ceiling;
        end else if (sum[CostW]) begin
            cost = cfg.cost_ceiling;
        end else begin
            cost = sum[CostW-1:0];
        end
        return cost;
    endfunction

    assign o_s_tready = !r_in_valid || !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);

    always_comb begin
        in_item.opcode           = i_s_tuser;
        in_item.a_present        = i_s_tdata[0];
        in_item.a_id             = i_s_tdata[8:1] & IdMask;
        in_item.a_etx            = i_s_tdata[24:9];
        in_item.a_rank           = i_s_tdata[40:25];
        in_item.b_present        = i_s_tdata[41];
        in_item.b_id             = i_s_tdata[49:42] & IdMask;
        in_item.b_etx            = i_s_tdata[65:50];
        in_item.b_rank           = i_s_tdata[81:66];
        in_item.base_hint        = i_s_tdata[97:82];
        in_item.preferred_in_use = i_s_tdata[98];
    end

    always_comb begin
        cost_a   = f_path_cost(r_cfg, r_in.a_present, r_in.a_etx, r_in.a_rank);
        cost_b   = f_path_cost(r_cfg, r_in.b_present, r_in.b_etx, r_in.b_rank);
        hop_sum  = {1'b0, r_in.a_rank} + {1'b0, r_cfg.min_hop_increase};
        hop_rank = hop_sum[CostW] ? '1 : hop_sum[CostW-1:0];
        thr_a    = {1'b0, cost_a} + {1'b0, r_cfg.switch_threshold};
        thr_b    = {1'b0, cost_b} + {1'b0, r_cfg.switch_threshold};
        keep     = r_pref_valid && r_in.preferred_in_use
                   && ({1'b0, r_pref_cost} < thr_a) && ({1'b0, r_pref_cost} < thr_b);
        win_b       = !(cost_a < cost_b);
        win_present = win_b ? r_in.b_present : r_in.a_present;
        win_id      = win_b ? r_in.b_id : r_in.a_id;
        win_cost    = win_b ? cost_b : cost_a;

        n_out        = '0;
        n_pref_valid = r_pref_valid;
        n_pref_id    = r_pref_id;
        n_pref_cost  = r_pref_cost;
        case (t_opcode'(r_in.opcode))
            OP_RANK: begin
                if (!r_in.a_present) begin
                    n_out.node_rank = (r_in.base_hint == '0) ? r_cfg.infinite_rank_value
                                                             : r_cfg.default_hop_increase;
                end else if (cost_a < r_cfg.cost_ceiling) begin
                    n_out.node_rank = (hop_rank > cost_a) ? hop_rank : cost_a;
                end else begin
                    n_out.node_rank = r_cfg.infinite_rank_value;
                end
            end
            OP_CHOOSE: begin
                if (keep) begin
                    n_out.chosen_id      = r_pref_id;
                    n_out.chosen_present = 1'b1;
                    n_out.kept_previous  = 1'b1;
                end else begin
                    n_pref_valid         = win_present;
                    n_pref_id            = win_present ? win_id : '0;
                    n_pref_cost          = win_cost;
                    n_out.chosen_id      = win_present ? win_id : '0;
                    n_out.chosen_present = win_present;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cost_ceiling         <= RstMaxPathCost;
            r_cfg.link_cost_limit      <= RstMaxLinkMetric;
            r_cfg.etx_multiplier       <= RstEtxMultiplier;
            r_cfg.switch_threshold     <= RstSwitchThresh;
            r_cfg.default_hop_increase <= RstDefHopInc;
            r_cfg.infinite_rank_value  <= RstInfRank;
            r_cfg.min_hop_increase     <= RstMinHopInc;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COST_CEILING:    r_cfg.cost_ceiling         <= i_cfg_wdata;
                REG_LINK_LIMIT:      r_cfg.link_cost_limit      <= i_cfg_wdata;
                REG_ETX_MULTIPLIER:  r_cfg.etx_multiplier       <= i_cfg_wdata[MultW-1:0];
                REG_SWITCH_THRESH:   r_cfg.switch_threshold     <= i_cfg_wdata;
                REG_DEF_HOP_INC:     r_cfg.default_hop_increase <= i_cfg_wdata;
                REG_INF_RANK:        r_cfg.infinite_rank_value  <= i_cfg_wdata;
                REG_MIN_HOP_INC:     r_cfg.min_hop_increase     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pref_valid <= 1'b0;
            r_pref_id    <= '0;
            r_pref_cost  <= RstMaxPathCost;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_pref_valid <= n_pref_valid;
                r_pref_id    <= n_pref_id;
                r_pref_cost  <= n_pref_cost;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OutDataW'(r_out);

    `ASSERT_CLK(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready |-> (r_in_valid && r_out_valid), "input stalled with a free stage")
    `ASSERT_CLK(a_pref_rise_has_result, i_clk, i_rst_n, $rose(r_pref_valid) |-> (o_m_tvalid && r_out.chosen_present), "preferred parent set without a present result")
    `ASSERT_ALWAYS(a_pref_id_cleared, i_clk, !r_pref_valid |-> (r_pref_id == '0), "stale id held without a preferred parent")
    `ASSERT_CLK(a_kept_is_present, i_clk, i_rst_n, (o_m_tvalid && r_out.kept_previous) |-> r_out.chosen_present, "kept parent reported absent")

endmodule
